### design/knob_dimming_curve_stepper_defines.svh
// Assertion macros for the knob dimming curve stepper checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef KNOB_DIMMING_CURVE_STEPPER_DEFINES_SVH
`define KNOB_DIMMING_CURVE_STEPPER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define KDCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define KDCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/kdcs_pkg.sv
// Package for the knob dimming curve stepper: widths, codes and the
// elaboration-time curve functions that fill the curve ROMs. No dependencies.
package kdcs_pkg;

    // Field widths
    localparam int KEY_W    = 8;
    localparam int BRIGHT_W = 10;
    localparam int TEMP_W   = 13;
    localparam int NAV_W    = 2;
    localparam int CURVE_W  = 2;
    localparam int ACTION_W = 4;
    localparam int NUM_CURVES = 4;

    // Curve step counts and position widths
    localparam int BRIGHT_STEPS = 1000;
    localparam int TEMP_STEPS   = 76;
    localparam int BRIGHT_POS_W = $clog2(BRIGHT_STEPS + 1);
    localparam int TEMP_POS_W   = $clog2(TEMP_STEPS + 1);
    localparam logic [BRIGHT_POS_W-1:0] BRIGHT_POS_MAX = BRIGHT_POS_W'(BRIGHT_STEPS);
    localparam logic [TEMP_POS_W-1:0]   TEMP_POS_MAX   = TEMP_POS_W'(TEMP_STEPS);

    // Output ranges
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX    = BRIGHT_W'(1000);
    localparam logic [TEMP_W-1:0]   TEMP_MIN      = TEMP_W'(2700);
    localparam logic [TEMP_W-1:0]   TEMP_MAX      = TEMP_W'(6500);
    localparam logic [TEMP_W-1:0]   TEMP_LIN_STEP = TEMP_W'(50);

    typedef enum logic [CURVE_W-1:0] {
        CURVE_LINEAR = 2'd0,
        CURVE_S      = 2'd1,
        CURVE_EXP    = 2'd2,
        CURVE_LOG    = 2'd3
    } curve_t;

    typedef enum logic [NAV_W-1:0] {
        NAV_NONE   = 2'd0,
        NAV_MENU   = 2'd1,
        NAV_TEMP   = 2'd2,
        NAV_EFFECT = 2'd3
    } nav_t;

    // Key actions, upper nibble of the key word
    localparam logic [ACTION_W-1:0] KEY_BRIGHT_DN = 4'd1;
    localparam logic [ACTION_W-1:0] KEY_BRIGHT_UP = 4'd2;
    localparam logic [ACTION_W-1:0] KEY_TEMP_DN   = 4'd3;
    localparam logic [ACTION_W-1:0] KEY_TEMP_UP   = 4'd4;
    localparam logic [ACTION_W-1:0] KEY_MENU      = 4'd7;
    localparam logic [ACTION_W-1:0] KEY_TEMP_SCR  = 4'd8;
    localparam logic [ACTION_W-1:0] KEY_EFFECT    = 4'd9;
    localparam logic [ACTION_W-1:0] KEY_BACK      = 4'd10;

    // Q30 fixed point used by the curve builders
    typedef logic [63:0] u64_t;
    localparam int   QF        = 30;
    localparam u64_t QONE      = u64_t'(1) << QF;
    localparam u64_t QMASK     = QONE - u64_t'(1);
    localparam u64_t QHALF     = u64_t'(1) << (QF - 1);
    localparam u64_t QINT_OFS  = u64_t'(QF) << QF;
    localparam u64_t LN2_Q     = u64_t'(744261118);
    localparam u64_t GAMMA_Q   = (u64_t'(22) * QONE) / 10;
    localparam u64_t TLO_EXP_Q = (u64_t'(27) * QONE) / 10;
    localparam u64_t THI_EXP_Q = (u64_t'(65) * QONE) / 10;
    localparam u64_t BRIGHT_HALF_Q = u64_t'(500);
    localparam u64_t TEMP_HALF_Q   = u64_t'(1900);
    localparam u64_t EXP_BASE  = u64_t'(101);
    localparam u64_t LOG_SPAN  = u64_t'(1023);

    // Divide by the Taylor term index (1..24)
    function automatic u64_t div_term(u64_t x, int k);
        u64_t q;
        case (k)
            1:       q = x / 1;
            2:       q = x / 2;
            3:       q = x / 3;
            4:       q = x / 4;
            5:       q = x / 5;
            6:       q = x / 6;
            7:       q = x / 7;
            8:       q = x / 8;
            9:       q = x / 9;
            10:      q = x / 10;
            11:      q = x / 11;
            12:      q = x / 12;
            13:      q = x / 13;
            14:      q = x / 14;
            15:      q = x / 15;
            16:      q = x / 16;
            17:      q = x / 17;
            18:      q = x / 18;
            19:      q = x / 19;
            20:      q = x / 20;
            21:      q = x / 21;
            22:      q = x / 22;
            23:      q = x / 23;
            24:      q = x / 24;
            default: q = x;
        endcase
        return q;
    endfunction

    // 2^f for f in [0,1), Taylor series of e^(f ln2)
    function automatic u64_t exp2_frac(u64_t f);
        u64_t z;
        u64_t sum;
        u64_t term;
        z = ((f & QMASK) * LN2_Q) >> QF;
        sum = QONE;
        term = QONE;
        for (int k = 1; k <= 24; k++)
        begin
            term = div_term((term * z) >> QF, k);
            sum = sum + term;
        end
        return sum;
    endfunction

    function automatic u64_t exp2_pos(u64_t a);
        u64_t n;
        n = a >> QF;
        if (n > 30)
        begin
            n = 30;
        end
        return exp2_frac(a & QMASK) << n;
    endfunction

    function automatic u64_t exp2_neg(u64_t a);
        u64_t n;
        u64_t f;
        n = a >> QF;
        f = a & QMASK;
        if (f == 0)
        begin
            return (n > 30) ? u64_t'(0) : (QONE >> n);
        end
        if (n >= 30)
        begin
            return u64_t'(0);
        end
        return exp2_frac(QONE - f) >> (n + 1);
    endfunction

    // log2 of an integer, bit by bit through repeated squaring
    function automatic u64_t log2_int(u64_t u);
        u64_t y;
        u64_t frac;
        int m;
        frac = '0;
        m = 0;
        if (u == 0)
        begin
            return u64_t'(0);
        end
        for (int i = 0; i < 64; i++)
        begin
            if (u[i])
            begin
                m = i;
            end
        end
        if (m > QF)
        begin
            y = u >> (m - QF);
        end
        else
        begin
            y = u << (QF - m);
        end
        for (int i = 0; i < QF; i++)
        begin
            y = (y * y) >> QF;
            if (y >= (QONE << 1))
            begin
                y = y >> 1;
                frac = frac | (u64_t'(1) << (QF - 1 - i));
            end
        end
        return (u64_t'(m) << QF) | frac;
    endfunction

    // (num/steps)^2.2 in Q30
    function automatic u64_t pow_gamma(u64_t num, bit is_temp);
        u64_t den;
        u64_t w;
        u64_t l;
        u64_t e;
        u64_t n;
        den = is_temp ? u64_t'(TEMP_STEPS) : u64_t'(BRIGHT_STEPS);
        n = num;
        if (n == 0)
        begin
            return u64_t'(0);
        end
        if (n > den)
        begin
            n = den;
        end
        if (is_temp)
        begin
            w = (n << QF) / TEMP_STEPS;
        end
        else
        begin
            w = (n << QF) / BRIGHT_STEPS;
        end
        if (w == 0)
        begin
            return u64_t'(0);
        end
        l = QINT_OFS - log2_int(w);
        e = l * (GAMMA_Q >> QF) + ((l * (GAMMA_Q & QMASK)) >> QF);
        return exp2_neg(e);
    endfunction

    function automatic u64_t s_curve(u64_t pos, bit is_temp);
        u64_t steps;
        u64_t half;
        u64_t base;
        steps = is_temp ? u64_t'(TEMP_STEPS) : u64_t'(BRIGHT_STEPS);
        half = is_temp ? TEMP_HALF_Q : BRIGHT_HALF_Q;
        base = half * QONE;
        if (u64_t'(2) * pos <= steps)
        begin
            return (base - half * pow_gamma(steps - u64_t'(2) * pos, is_temp) + QHALF) >> QF;
        end
        return (base + half * pow_gamma(u64_t'(2) * pos - steps, is_temp) + QHALF) >> QF;
    endfunction

    // Brightness ROM entry for a curve and a step position, clamped
    function automatic logic [BRIGHT_W-1:0] bright_curve_value(int curve, int pos);
        u64_t p;
        u64_t v;
        u64_t w;
        p = u64_t'(pos);
        v = '0;
        case (curve)
            1:
            begin
                v = s_curve(p, 1'b0);
            end
            2:
            begin
                w = exp2_pos(log2_int(EXP_BASE) * p / BRIGHT_STEPS) * u64_t'(10) + QHALF;
                v = (w < u64_t'(10) * QONE) ? u64_t'(0) : ((w - u64_t'(10) * QONE) >> QF);
            end
            3:
            begin
                w = ((LOG_SPAN * p + u64_t'(BRIGHT_STEPS)) << QF) / BRIGHT_STEPS;
                v = (u64_t'(100) * (log2_int(w) - QINT_OFS) + QHALF) >> QF;
            end
            default:
            begin
                v = '0;
            end
        endcase
        if (v > u64_t'(BRIGHT_MAX))
        begin
            v = u64_t'(BRIGHT_MAX);
        end
        return v[BRIGHT_W-1:0];
    endfunction

    // Temperature ROM entry for a curve and a step position, clamped
    function automatic logic [TEMP_W-1:0] temp_curve_value(int curve, int pos);
        u64_t p;
        u64_t v;
        u64_t a;
        u64_t b;
        u64_t w;
        p = u64_t'(pos);
        v = '0;
        case (curve)
            1:
            begin
                v = u64_t'(TEMP_MIN) + s_curve(p, 1'b1);
            end
            2:
            begin
                a = log2_int(u64_t'(TEMP_MIN));
                b = log2_int(u64_t'(TEMP_MAX)) - a;
                v = (exp2_pos(a + b * p / TEMP_STEPS) + QHALF) >> QF;
            end
            3:
            begin
                a = exp2_pos(TLO_EXP_Q);
                b = exp2_pos(THI_EXP_Q);
                w = a + (b - a) * p / TEMP_STEPS;
                v = (u64_t'(1000) * (log2_int(w) - QINT_OFS) + QHALF) >> QF;
            end
            default:
            begin
                v = '0;
            end
        endcase
        if (v < u64_t'(TEMP_MIN))
        begin
            v = u64_t'(TEMP_MIN);
        end
        if (v > u64_t'(TEMP_MAX))
        begin
            v = u64_t'(TEMP_MAX);
        end
        return v[TEMP_W-1:0];
    endfunction

endpackage

### design/knob_dimming_curve_stepper.sv
// Knob dimming curve stepper, top level.
// Depends on kdcs_pkg for widths, codes and the curve ROM contents.
//
// Takes one key word per cycle while out_ready is high and returns one result
// word per key, with the brightness and color temperature after that key and
// any navigation request. A word takes three register stages from acceptance
// to out_valid (input register, curve position update with the registered
// curve ROM read, result register). The rate is set by the step position
// registers, which are read and written once per key, and by the single
// registered read port of each curve ROM. The ROMs hold every curve value
// precomputed at elaboration (1001 brightness and 77 temperature entries per
// curve). curve_type may only be written while no word is in flight.
module knob_dimming_curve_stepper
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [kdcs_pkg::CURVE_W-1:0]     cfg_wr_data,
    // key input
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [kdcs_pkg::KEY_W-1:0]       key_code,
    // result output
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [kdcs_pkg::BRIGHT_W-1:0]    brightness_tenths,
    output logic [kdcs_pkg::TEMP_W-1:0]      temperature_kelvin,
    output logic [kdcs_pkg::NAV_W-1:0]       nav_request
);
    import kdcs_pkg::*;

    // Curve ROMs, built from constants at elaboration
    logic [BRIGHT_W-1:0] bright_rom [0:NUM_CURVES-1][0:BRIGHT_STEPS];
    logic [TEMP_W-1:0]   temp_rom   [0:NUM_CURVES-1][0:TEMP_STEPS];

    for (genvar c = 0; c < NUM_CURVES; c++)
    begin : g_curve
        for (genvar p = 0; p <= BRIGHT_STEPS; p++)
        begin : g_bright
            localparam logic [BRIGHT_W-1:0] ENTRY = bright_curve_value(c, p);
            assign bright_rom[c][p] = ENTRY;
        end
        for (genvar p = 0; p <= TEMP_STEPS; p++)
        begin : g_temp
            localparam logic [TEMP_W-1:0] ENTRY = temp_curve_value(c, p);
            assign temp_rom[c][p] = ENTRY;
        end
    end

    // Registers
    curve_t                  curve_type_reg;
    logic                    s1_valid_reg;
    logic [KEY_W-1:0]        key_reg;
    logic                    s2_valid_reg;
    logic [ACTION_W-1:0]     s2_action_reg;
    logic [BRIGHT_W-1:0]     bright_rd_reg;
    logic [TEMP_W-1:0]       temp_rd_reg;
    logic                    out_valid_reg;
    logic [BRIGHT_W-1:0]     out_bright_reg;
    logic [TEMP_W-1:0]       out_temp_reg;
    nav_t                    out_nav_reg;
    logic [BRIGHT_W-1:0]     bright_value_reg;
    logic [TEMP_W-1:0]       temp_value_reg;
    logic [BRIGHT_POS_W-1:0] bright_s_pos_reg;
    logic [BRIGHT_POS_W-1:0] bright_exp_pos_reg;
    logic [BRIGHT_POS_W-1:0] bright_log_pos_reg;
    logic [TEMP_POS_W-1:0]   temp_s_pos_reg;
    logic [TEMP_POS_W-1:0]   temp_exp_pos_reg;
    logic [TEMP_POS_W-1:0]   temp_log_pos_reg;

    // Pipeline flow control
    logic out_free;
    logic s2_adv;
    logic s2_free;
    logic s1_adv;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;

    // Stage 1: step the active curve position
    logic [ACTION_W-1:0]     s1_action;
    logic                    b_up;
    logic                    b_dn;
    logic                    t_up;
    logic                    t_dn;
    logic [BRIGHT_POS_W-1:0] b_pos_cur;
    logic [BRIGHT_POS_W-1:0] b_pos_next;
    logic [TEMP_POS_W-1:0]   t_pos_cur;
    logic [TEMP_POS_W-1:0]   t_pos_next;

    assign s1_action = key_reg[KEY_W-1:KEY_W-ACTION_W];
    assign b_up = (s1_action == KEY_BRIGHT_UP);
    assign b_dn = (s1_action == KEY_BRIGHT_DN);
    assign t_up = (s1_action == KEY_TEMP_UP);
    assign t_dn = (s1_action == KEY_TEMP_DN);

    always_comb
    begin
        case (curve_type_reg)
            CURVE_S:
            begin
                b_pos_cur = bright_s_pos_reg;
                t_pos_cur = temp_s_pos_reg;
            end
            CURVE_EXP:
            begin
                b_pos_cur = bright_exp_pos_reg;
                t_pos_cur = temp_exp_pos_reg;
            end
            default:
            begin
                b_pos_cur = bright_log_pos_reg;
                t_pos_cur = temp_log_pos_reg;
            end
        endcase

        b_pos_next = b_pos_cur;
        if (b_up && (b_pos_cur < BRIGHT_POS_MAX))
        begin
            b_pos_next = b_pos_cur + BRIGHT_POS_W'(1);
        end
        else if (b_dn && (b_pos_cur != '0))
        begin
            b_pos_next = b_pos_cur - BRIGHT_POS_W'(1);
        end

        t_pos_next = t_pos_cur;
        if (t_up && (t_pos_cur < TEMP_POS_MAX))
        begin
            t_pos_next = t_pos_cur + TEMP_POS_W'(1);
        end
        else if (t_dn && (t_pos_cur != '0))
        begin
            t_pos_next = t_pos_cur - TEMP_POS_W'(1);
        end
    end

    // Stage 2: pick the new values and decode navigation
    logic [BRIGHT_W-1:0] b_lin;
    logic [TEMP_W-1:0]   t_lin;
    logic [BRIGHT_W-1:0] b_final;
    logic [TEMP_W-1:0]   t_final;
    nav_t                nav_next;
    logic                s2_bright_op;
    logic                s2_temp_op;
    logic                s2_up;

    assign s2_bright_op = (s2_action_reg == KEY_BRIGHT_UP) || (s2_action_reg == KEY_BRIGHT_DN);
    assign s2_temp_op   = (s2_action_reg == KEY_TEMP_UP) || (s2_action_reg == KEY_TEMP_DN);
    assign s2_up        = (s2_action_reg == KEY_BRIGHT_UP) || (s2_action_reg == KEY_TEMP_UP);

    always_comb
    begin
        // linear steps on the current values
        if (s2_up)
        begin
            b_lin = (bright_value_reg < BRIGHT_MAX) ? bright_value_reg + BRIGHT_W'(1)
                                                    : bright_value_reg;
            t_lin = (temp_value_reg > TEMP_MAX - TEMP_LIN_STEP) ? TEMP_MAX
                                                               : temp_value_reg + TEMP_LIN_STEP;
        end
        else
        begin
            b_lin = (bright_value_reg != '0) ? bright_value_reg - BRIGHT_W'(1)
                                             : bright_value_reg;
            t_lin = (temp_value_reg < TEMP_MIN + TEMP_LIN_STEP) ? TEMP_MIN
                                                               : temp_value_reg - TEMP_LIN_STEP;
        end

        b_final = bright_value_reg;
        if (s2_bright_op)
        begin
            b_final = (curve_type_reg == CURVE_LINEAR) ? b_lin : bright_rd_reg;
        end

        t_final = temp_value_reg;
        if (s2_temp_op)
        begin
            t_final = (curve_type_reg == CURVE_LINEAR) ? t_lin : temp_rd_reg;
        end

        unique case (s2_action_reg) inside
            KEY_MENU, KEY_BACK: nav_next = NAV_MENU;
            KEY_TEMP_SCR:       nav_next = NAV_TEMP;
            KEY_EFFECT:         nav_next = NAV_EFFECT;
            default:            nav_next = NAV_NONE;
        endcase
    end

    // Control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_type_reg     <= CURVE_LINEAR;
            s1_valid_reg       <= 1'b0;
            s2_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            bright_value_reg   <= '0;
            temp_value_reg     <= TEMP_MIN;
            bright_s_pos_reg   <= '0;
            bright_exp_pos_reg <= '0;
            bright_log_pos_reg <= '0;
            temp_s_pos_reg     <= '0;
            temp_exp_pos_reg   <= '0;
            temp_log_pos_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                curve_type_reg <= curve_t'(cfg_wr_data);
            end

            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_adv;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_adv;
            end

            // only the active curve's positions move
            if (s1_adv)
            begin
                case (curve_type_reg)
                    CURVE_S:
                    begin
                        bright_s_pos_reg <= b_pos_next;
                        temp_s_pos_reg   <= t_pos_next;
                    end
                    CURVE_EXP:
                    begin
                        bright_exp_pos_reg <= b_pos_next;
                        temp_exp_pos_reg   <= t_pos_next;
                    end
                    CURVE_LOG:
                    begin
                        bright_log_pos_reg <= b_pos_next;
                        temp_log_pos_reg   <= t_pos_next;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (s2_adv)
            begin
                bright_value_reg <= b_final;
                temp_value_reg   <= t_final;
            end
        end
    end

    // Payload registers and ROM reads
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            key_reg <= key_code;
        end
        if (s1_adv)
        begin
            s2_action_reg <= s1_action;
            bright_rd_reg <= bright_rom[curve_type_reg][b_pos_next];
            temp_rd_reg   <= temp_rom[curve_type_reg][t_pos_next];
        end
        if (s2_adv)
        begin
            out_bright_reg <= b_final;
            out_temp_reg   <= t_final;
            out_nav_reg    <= nav_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign brightness_tenths  = out_bright_reg;
    assign temperature_kelvin = out_temp_reg;
    assign nav_request        = out_nav_reg;

endmodule

### design/kdcs_checker.sv
// Port-level checker for the knob dimming curve stepper, bound to the top.
// Depends on kdcs_pkg and knob_dimming_curve_stepper_defines.svh.
`include "knob_dimming_curve_stepper_defines.svh"

module kdcs_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [kdcs_pkg::BRIGHT_W-1:0] brightness_tenths,
    input logic [kdcs_pkg::TEMP_W-1:0]   temperature_kelvin,
    input logic [kdcs_pkg::NAV_W-1:0]    nav_request
);
    import kdcs_pkg::*;

    // result word as one vector, stall and range terms
    logic [BRIGHT_W+TEMP_W+NAV_W-1:0] out_word;
    logic                             out_stall;
    logic                             bright_in_range;
    logic                             temp_in_range;

    assign out_word        = {brightness_tenths, temperature_kelvin, nav_request};
    assign out_stall       = out_valid && !out_ready;
    assign bright_in_range = (brightness_tenths <= BRIGHT_MAX);
    assign temp_in_range   = (temperature_kelvin >= TEMP_MIN) && (temperature_kelvin <= TEMP_MAX);

    // a stalled result word holds
    `KDCS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "result not held")

    // result values stay in their ranges
    `KDCS_ASSERT_NOW(a_bright_range, out_valid, bright_in_range, "brightness out of range")
    `KDCS_ASSERT_NOW(a_temp_range, out_valid, temp_in_range, "temperature out of range")

    // input only backs up once every stage is full and the output is stalled
    `KDCS_ASSERT_NOW(a_ready_backpressure, !in_ready, out_stall, "input stalled with room left")

endmodule

bind knob_dimming_curve_stepper kdcs_checker u_kdcs_checker (.*);
